// File: hw/rtl/tsph_pkg.sv
package tsph_pkg;

  localparam int unsigned PACKET_BYTES = 188;
  localparam int unsigned REC_DEPTH    = 4;

  localparam logic [7:0] SYNC_CODE = 8'h47;

  localparam logic [3:0] KIND_HEADER  = 4'd0;
  localparam logic [3:0] KIND_PCR     = 4'd1;
  localparam logic [3:0] KIND_OPCR    = 4'd2;
  localparam logic [3:0] KIND_SPLICE  = 4'd3;
  localparam logic [3:0] KIND_PRIVLEN = 4'd4;
  localparam logic [3:0] KIND_LTW     = 4'd5;
  localparam logic [3:0] KIND_RATE    = 4'd6;
  localparam logic [3:0] KIND_SEAM    = 4'd7;
  localparam logic [3:0] KIND_PAYLOAD = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SYNC = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_HDR      = 4'd1,
    PH_ALEN     = 4'd2,
    PH_AFLAGS   = 4'd3,
    PH_PCR      = 4'd4,
    PH_OPCR     = 4'd5,
    PH_SPLICE   = 4'd6,
    PH_PRIVLEN  = 4'd7,
    PH_PRIVSKIP = 4'd8,
    PH_EXT      = 4'd9,
    PH_LTW      = 4'd10,
    PH_RATE     = 4'd11,
    PH_SEAM     = 4'd12,
    PH_STUFF    = 4'd13,
    PH_PAYLOAD  = 4'd15
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_first;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [12:0] packet_id;
    logic        error_flag;
    logic        unit_start;
    logic        priority_flag;
    logic [1:0]  scrambling;
    logic [1:0]  field_control;
    logic [3:0]  continuity;
    logic [32:0] value_main;
    logic [8:0]  value_aux;
    logic [1:0]  status;
    logic        last_of_packet;
  } out_rec_t;

  // records produced by one byte, oldest in rec0
  typedef struct packed {
    logic [1:0] count;
    out_rec_t   rec0;
    out_rec_t   rec1;
  } push_t;

endpackage

// File: hw/rtl/ts_packet_header_parser.sv
// Transport stream packet header parser.
// Byte side: byte_valid / byte_stall / byte_data carry one stream byte per request,
// with packet_first marking byte 0 of a packet (forces the position count to 0).
// Record side: rec_valid / rec_stall / rec_data carry one decoded record per request:
// header, adaptation field entries (PCR, OPCR, splice, private length, LTW, rate,
// seamless splice) and a closing payload record with offset and length, or a
// bad-sync / truncation record.
// Throughput: one byte per cycle while the record queue has room; a byte yields zero,
// one or two records. A byte waits in the input register, its records then go into
// a four-entry record queue, and the record side offers them from that queue.
// The byte side stalls only when the record queue cannot take two more records,
// so a stalled record side holds back bytes once the queue fills up.
// Reset clears the parse state to awaiting sync and empties the record queue;
// nothing is reported until a byte at position 0 arrives.
module ts_packet_header_parser import tsph_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_stall,
  input  in_item_t byte_data,
  output logic     rec_valid,
  input  logic     rec_stall,
  output out_rec_t rec_data
);

  logic     in_vld;
  in_item_t in_q;
  logic     room;
  logic     step;
  push_t    push;

  assign step       = in_vld && room;
  assign byte_stall = in_vld && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_vld <= 1'b1;
    end else if (step) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_q <= byte_data;
    end
  end

  tsph_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_q),
    .push (push)
  );

  tsph_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .stall (rec_stall),
    .valid (rec_valid),
    .data  (rec_data),
    .room  (room)
  );

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !room) |=> (in_vld && $stable(in_q)))
    else $error("held byte lost while queue full");

endmodule

// File: hw/rtl/tsph_parse.sv
module tsph_parse import tsph_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  in_item_t item,
  output push_t    push
);

  typedef enum logic [1:0] {ACT_NONE, ACT_TRUNC, ACT_PAY, ACT_ADV} act_t;

  localparam logic [8:0] PKT_LEN  = 9'(PACKET_BYTES);
  localparam logic [7:0] ALEN_MAX = 8'(PACKET_BYTES - 5);

  phase_t      phase, phase_next;
  logic [7:0]  bpos, bpos_next;
  logic [47:0] shift, shift_next;
  logic [7:0]  fbl, fbl_next;
  logic [7:0]  abl, abl_next;
  logic [4:0]  aflags, aflags_next;
  logic [2:0]  eflags, eflags_next;
  logic [23:0] hl, hl_next;

  logic [7:0]  pos;
  logic [8:0]  pos_inc;
  logic [7:0]  b;
  act_t        act;
  logic [8:0]  pay_off;
  logic [8:0]  pay_len;
  phase_t      nph;
  logic [7:0]  need;
  logic        adv_go;
  push_t       p;

  function automatic out_rec_t mk_rec(logic [3:0] kind, logic [23:0] h, logic [32:0] vm,
                                      logic [8:0] va, logic [1:0] st, logic last);
    out_rec_t r;
    r.record_kind    = kind;
    r.packet_id      = h[20:8];
    r.error_flag     = h[23];
    r.unit_start     = h[22];
    r.priority_flag  = h[21];
    r.scrambling     = h[7:6];
    r.field_control  = h[5:4];
    r.continuity     = h[3:0];
    r.value_main     = vm;
    r.value_aux      = va;
    r.status         = st;
    r.last_of_packet = last;
    return r;
  endfunction

  function automatic push_t push_rec(push_t q, out_rec_t r);
    push_t o;
    o = q;
    if (q.count == 2'd0) begin
      o.rec0 = r;
    end else begin
      o.rec1 = r;
    end
    o.count = q.count + 2'd1;
    return o;
  endfunction

  function automatic logic [7:0] dec_sat(logic [7:0] x);
    return (x != 8'd0) ? x - 8'd1 : x;
  endfunction

  always_comb begin
    pos         = item.packet_first ? 8'd0 : bpos;
    pos_inc     = {1'b0, pos} + 9'd1;
    b           = item.data_byte;
    phase_next  = phase;
    shift_next  = shift;
    fbl_next    = fbl;
    abl_next    = abl;
    aflags_next = aflags;
    eflags_next = eflags;
    hl_next     = hl;
    act         = ACT_NONE;
    pay_off     = pos_inc;
    pay_len     = 9'd0;
    nph         = PH_IDLE;
    need        = 8'd0;
    adv_go      = 1'b0;
    p           = '0;

    if (pos == 8'd0) begin
      // new packet before the old one finished: close the old one first
      if (phase != PH_IDLE && phase != PH_PAYLOAD) begin
        p = push_rec(p, mk_rec(KIND_PAYLOAD, hl, 33'd0, 9'd0, ST_TRUNC, 1'b1));
      end
      hl_next     = 24'd0;
      shift_next  = 48'd0;
      fbl_next    = 8'd0;
      abl_next    = 8'd0;
      aflags_next = 5'd0;
      eflags_next = 3'd0;
      if (b != SYNC_CODE) begin
        phase_next = PH_IDLE;
        p = push_rec(p, mk_rec(KIND_HEADER, 24'd0, 33'd0, 9'd0, ST_BAD_SYNC, 1'b1));
      end else begin
        phase_next = PH_HDR;
      end
    end else begin
      unique case (phase) inside
        PH_HDR: begin
          hl_next = {hl[15:0], b};
          if (pos >= 8'd3) begin
            p = push_rec(p, mk_rec(KIND_HEADER, hl_next, 33'd0, 9'd0, ST_OK, 1'b0));
            if (hl_next[5]) begin
              phase_next = PH_ALEN;
            end else begin
              act     = ACT_PAY;
              pay_off = 9'd4;
            end
          end
        end
        PH_ALEN: begin
          if (b > ALEN_MAX) begin
            act = ACT_TRUNC;
          end else begin
            abl_next = b;
            if (b == 8'd0) begin
              act = ACT_PAY;
            end else begin
              phase_next = PH_AFLAGS;
            end
          end
        end
        PH_AFLAGS: begin
          abl_next    = dec_sat(abl);
          aflags_next = b[4:0];
          act         = ACT_ADV;
        end
        PH_PRIVSKIP: begin
          abl_next = dec_sat(abl);
          fbl_next = dec_sat(fbl);
          if (fbl_next == 8'd0) begin
            act = ACT_ADV;
          end
        end
        PH_STUFF: begin
          abl_next = dec_sat(abl);
          if (abl_next == 8'd0) begin
            act = ACT_PAY;
          end
        end
        PH_PCR, PH_OPCR, PH_SPLICE, PH_PRIVLEN, PH_EXT, PH_LTW, PH_RATE, PH_SEAM: begin
          shift_next = {shift[39:0], b};
          abl_next   = dec_sat(abl);
          fbl_next   = dec_sat(fbl);
          if (fbl_next == 8'd0) begin
            act = ACT_ADV;
            case (phase)
              PH_PCR: p = push_rec(p, mk_rec(KIND_PCR, hl_next, shift_next[47:15],
                                             shift_next[8:0], ST_OK, 1'b0));
              PH_OPCR: p = push_rec(p, mk_rec(KIND_OPCR, hl_next, shift_next[47:15],
                                              shift_next[8:0], ST_OK, 1'b0));
              PH_SPLICE: p = push_rec(p, mk_rec(KIND_SPLICE, hl_next,
                                                {25'd0, shift_next[7:0]}, 9'd0, ST_OK, 1'b0));
              PH_PRIVLEN: begin
                p = push_rec(p, mk_rec(KIND_PRIVLEN, hl_next, {25'd0, shift_next[7:0]},
                                       9'd0, ST_OK, 1'b0));
                if (shift_next[7:0] != 8'd0) begin
                  if (shift_next[7:0] > abl_next) begin
                    act = ACT_TRUNC;
                  end else begin
                    phase_next = PH_PRIVSKIP;
                    fbl_next   = shift_next[7:0];
                    act        = ACT_NONE;
                  end
                end
              end
              PH_EXT: eflags_next = shift_next[7:5];
              PH_LTW: p = push_rec(p, mk_rec(KIND_LTW, hl_next, {18'd0, shift_next[14:0]},
                                             {8'd0, shift_next[15]}, ST_OK, 1'b0));
              PH_RATE: p = push_rec(p, mk_rec(KIND_RATE, hl_next, {11'd0, shift_next[21:0]},
                                              9'd0, ST_OK, 1'b0));
              default: p = push_rec(p, mk_rec(KIND_SEAM, hl_next,
                                              {shift_next[35:33], shift_next[31:17],
                                               shift_next[15:1]},
                                              {5'd0, shift_next[39:36]}, ST_OK, 1'b0));
            endcase
          end
        end
        default: ;
      endcase
    end

    // pick the next adaptation field in flag order
    if (act == ACT_ADV) begin
      adv_go = 1'b1;
      if (aflags_next[4]) begin
        aflags_next[4] = 1'b0; nph = PH_PCR; need = 8'd6;
      end else if (aflags_next[3]) begin
        aflags_next[3] = 1'b0; nph = PH_OPCR; need = 8'd6;
      end else if (aflags_next[2]) begin
        aflags_next[2] = 1'b0; nph = PH_SPLICE; need = 8'd1;
      end else if (aflags_next[1]) begin
        aflags_next[1] = 1'b0; nph = PH_PRIVLEN; need = 8'd1;
      end else if (aflags_next[0]) begin
        aflags_next[0] = 1'b0; nph = PH_EXT; need = 8'd2;
      end else if (eflags_next[2]) begin
        eflags_next[2] = 1'b0; nph = PH_LTW; need = 8'd2;
      end else if (eflags_next[1]) begin
        eflags_next[1] = 1'b0; nph = PH_RATE; need = 8'd3;
      end else if (eflags_next[0]) begin
        eflags_next[0] = 1'b0; nph = PH_SEAM; need = 8'd5;
      end else begin
        adv_go = 1'b0;
      end
      if (adv_go) begin
        if (need > abl_next) begin
          act = ACT_TRUNC;
        end else begin
          phase_next = nph;
          fbl_next   = need;
          shift_next = 48'd0;
          act        = ACT_NONE;
        end
      end else if (abl_next == 8'd0) begin
        act = ACT_PAY;
      end else begin
        phase_next = PH_STUFF;
        act        = ACT_NONE;
      end
    end

    if (act == ACT_TRUNC) begin
      phase_next = PH_IDLE;
      p = push_rec(p, mk_rec(KIND_PAYLOAD, hl_next, 33'd0, 9'd0, ST_TRUNC, 1'b1));
    end else if (act == ACT_PAY) begin
      // length only when the packet carries payload
      if (hl_next[4] && pay_off <= PKT_LEN) begin
        pay_len = PKT_LEN - pay_off;
      end
      phase_next = PH_PAYLOAD;
      p = push_rec(p, mk_rec(KIND_PAYLOAD, hl_next, {24'd0, pay_off}, pay_len, ST_OK, 1'b1));
    end

    bpos_next = (pos_inc >= PKT_LEN) ? 8'd0 : pos_inc[7:0];

    push = p;
    if (!step) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bpos  <= 8'd0;
    end else if (step) begin
      phase <= phase_next;
      bpos  <= bpos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift  <= shift_next;
      fbl    <= fbl_next;
      abl    <= abl_next;
      aflags <= aflags_next;
      eflags <= eflags_next;
      hl     <= hl_next;
    end
  end

  a_pair_ends_packet: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.rec1.last_of_packet)
    else $error("second record of a byte is not final");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd3)
    else $error("more than two records from one byte");

  a_payload_quiet: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_PAYLOAD && pos != 8'd0) |-> push.count == 2'd0)
    else $error("record produced inside payload");

endmodule

// File: hw/rtl/tsph_fifo.sv
module tsph_fifo import tsph_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  push_t    push,
  input  logic     stall,
  output logic     valid,
  output out_rec_t data,
  output logic     room
);

  localparam int unsigned PTR_W = $clog2(REC_DEPTH);
  localparam int unsigned CNT_W = $clog2(REC_DEPTH + 1);

  out_rec_t         mem [REC_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             pop;

  assign valid    = (cnt != '0);
  assign data     = mem[rd_ptr];
  assign pop      = valid && !stall;
  // space for two more after this cycle's read
  assign room     = (cnt - CNT_W'(pop)) <= CNT_W'(REC_DEPTH - 2);
  assign cnt_next = cnt + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      cnt    <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.rec1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(REC_DEPTH))
    else $error("record queue overflow");

endmodule

// File: tb/sv/ts_packet_header_parser_tb.sv
module ts_packet_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsph_pkg::*;

  localparam int unsigned ITEMS       = 850;
  localparam int unsigned CALM_AFTER  = 700;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic     clk        = 1'b0;
  logic     rst        = 1'b1;
  logic     byte_valid = 1'b0;
  logic     byte_stall;
  in_item_t byte_data  = '0;
  logic     rec_valid;
  logic     rec_stall  = 1'b0;
  out_rec_t rec_data;

  ts_packet_header_parser dut (.*);

  initial forever #1 clk = ~clk;

  // parser state as seen from the stream
  logic [7:0]  at_byte    = '0;
  phase_t      stage      = PH_IDLE;
  logic [63:0] shift_acc  = '0;
  logic [7:0]  field_left = '0;
  logic [7:0]  adapt_left = '0;
  logic [4:0]  af_flags   = '0;
  logic [2:0]  ext_flags  = '0;
  logic [23:0] hdr_bits   = '0;

  out_rec_t    due_records[$];
  int          errors     = 0;
  int unsigned sent_count = 0;
  bit          calm       = 1'b0;
  bit          gaps_on    = 1'b1;

  typedef struct {
    logic [7:0] b;
    logic       first;
    bit         typed;
    out_rec_t   want;
  } row_t;

  row_t script[$];

  function automatic void queue_record(logic [3:0] kind, logic [32:0] vmain,
                                       logic [8:0] vaux, logic [1:0] st, logic last);
    out_rec_t r;
    r.record_kind    = kind;
    r.packet_id      = hdr_bits[20:8];
    r.error_flag     = hdr_bits[23];
    r.unit_start     = hdr_bits[22];
    r.priority_flag  = hdr_bits[21];
    r.scrambling     = hdr_bits[7:6];
    r.field_control  = hdr_bits[5:4];
    r.continuity     = hdr_bits[3:0];
    r.value_main     = vmain;
    r.value_aux      = vaux;
    r.status         = st;
    r.last_of_packet = last;
    due_records.push_back(r);
  endfunction

  function automatic void abort_packet();
    stage = PH_IDLE;
    queue_record(KIND_PAYLOAD, '0, '0, ST_TRUNC, 1'b1);
  endfunction

  function automatic void close_packet(logic [7:0] off);
    logic [8:0] len;
    len = '0;
    // payload present for control 1 and 3
    if (hdr_bits[4] && off <= PACKET_BYTES) len = 9'(PACKET_BYTES - off);
    stage = PH_PAYLOAD;
    queue_record(KIND_PAYLOAD, 33'(off), len, ST_OK, 1'b1);
  endfunction

  function automatic void open_field(phase_t p, logic [7:0] need);
    if (need > adapt_left) begin
      abort_packet();
    end else begin
      stage      = p;
      field_left = need;
      shift_acc  = '0;
    end
  endfunction

  function automatic void next_field(logic [7:0] pos);
    if (af_flags[4]) begin
      af_flags[4] = 1'b0;
      open_field(PH_PCR, 8'd6);
    end else if (af_flags[3]) begin
      af_flags[3] = 1'b0;
      open_field(PH_OPCR, 8'd6);
    end else if (af_flags[2]) begin
      af_flags[2] = 1'b0;
      open_field(PH_SPLICE, 8'd1);
    end else if (af_flags[1]) begin
      af_flags[1] = 1'b0;
      open_field(PH_PRIVLEN, 8'd1);
    end else if (af_flags[0]) begin
      af_flags[0] = 1'b0;
      open_field(PH_EXT, 8'd2);
    end else if (ext_flags[2]) begin
      ext_flags[2] = 1'b0;
      open_field(PH_LTW, 8'd2);
    end else if (ext_flags[1]) begin
      ext_flags[1] = 1'b0;
      open_field(PH_RATE, 8'd3);
    end else if (ext_flags[0]) begin
      ext_flags[0] = 1'b0;
      open_field(PH_SEAM, 8'd5);
    end else if (adapt_left == 0) begin
      close_packet(pos + 8'd1);
    end else begin
      stage = PH_STUFF;
    end
  endfunction

  function automatic void finish_field(logic [7:0] pos);
    logic [7:0] lead;
    lead = shift_acc[39:32];
    case (stage)
      PH_PCR:    queue_record(KIND_PCR, shift_acc[47:15], shift_acc[8:0], ST_OK, 1'b0);
      PH_OPCR:   queue_record(KIND_OPCR, shift_acc[47:15], shift_acc[8:0], ST_OK, 1'b0);
      PH_SPLICE: queue_record(KIND_SPLICE, 33'(shift_acc[7:0]), '0, ST_OK, 1'b0);
      PH_PRIVLEN: begin
        queue_record(KIND_PRIVLEN, 33'(shift_acc[7:0]), '0, ST_OK, 1'b0);
        if (shift_acc[7:0] != 0) begin
          if (shift_acc[7:0] > adapt_left) begin
            abort_packet();
          end else begin
            stage      = PH_PRIVSKIP;
            field_left = shift_acc[7:0];
          end
          return;
        end
      end
      PH_EXT:  ext_flags = shift_acc[7:5];
      PH_LTW:  queue_record(KIND_LTW, 33'(shift_acc[14:0]), 9'(shift_acc[15]), ST_OK, 1'b0);
      PH_RATE: queue_record(KIND_RATE, 33'(shift_acc[21:0]), '0, ST_OK, 1'b0);
      default: begin
        // DTS is 3 + 15 + 15 bits, marker bits dropped
        queue_record(KIND_SEAM, {lead[3:1], shift_acc[31:17], shift_acc[15:1]},
                     9'(lead[7:4]), ST_OK, 1'b0);
      end
    endcase
    next_field(pos);
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic first);
    logic [7:0] pos;
    pos = first ? 8'd0 : at_byte;
    if (pos == 0) begin
      // an unfinished packet is closed off before the new one starts
      if (stage != PH_IDLE && stage != PH_PAYLOAD) abort_packet();
      hdr_bits   = '0;
      shift_acc  = '0;
      field_left = '0;
      adapt_left = '0;
      af_flags   = '0;
      ext_flags  = '0;
      if (b != SYNC_CODE) begin
        stage = PH_IDLE;
        queue_record(KIND_HEADER, '0, '0, ST_BAD_SYNC, 1'b1);
      end else begin
        stage = PH_HDR;
      end
    end else begin
      case (stage)
        PH_HDR: begin
          hdr_bits = {hdr_bits[15:0], b};
          if (pos >= 3) begin
            queue_record(KIND_HEADER, '0, '0, ST_OK, 1'b0);
            if (hdr_bits[5]) stage = PH_ALEN;
            else close_packet(8'd4);
          end
        end
        PH_ALEN: begin
          if (b > PACKET_BYTES - 5) begin
            abort_packet();
          end else begin
            adapt_left = b;
            if (b == 0) close_packet(pos + 8'd1);
            else stage = PH_AFLAGS;
          end
        end
        PH_AFLAGS: begin
          if (adapt_left != 0) adapt_left--;
          af_flags = b[4:0];
          next_field(pos);
        end
        PH_PRIVSKIP: begin
          if (adapt_left != 0) adapt_left--;
          if (field_left != 0) field_left--;
          if (field_left == 0) next_field(pos);
        end
        PH_STUFF: begin
          if (adapt_left != 0) adapt_left--;
          if (adapt_left == 0) close_packet(pos + 8'd1);
        end
        PH_PCR, PH_OPCR, PH_SPLICE, PH_PRIVLEN, PH_EXT, PH_LTW, PH_RATE, PH_SEAM: begin
          shift_acc = {shift_acc[55:0], b};
          if (adapt_left != 0) adapt_left--;
          if (field_left != 0) field_left--;
          if (field_left == 0) finish_field(pos);
        end
        default: ;
      endcase
    end
    at_byte = (pos + 1 >= PACKET_BYTES) ? 8'd0 : pos + 8'd1;
  endfunction

  function automatic void add_row(logic [7:0] b, logic first, bit typed = 1'b0,
                                  out_rec_t want = '0);
    row_t r;
    r.b     = b;
    r.first = first;
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endfunction

  function automatic out_rec_t closing_rec(logic [3:0] kind, logic [1:0] ctl, logic [1:0] st);
    out_rec_t r;
    r                = '0;
    r.record_kind    = kind;
    r.field_control  = ctl;
    r.status         = st;
    r.last_of_packet = 1'b1;
    return r;
  endfunction

  function automatic void check_field(string name, logic [32:0] want, logic [32:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic first, bit typed = 1'b0, out_rec_t want = '0);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= {b, first};
    do @(posedge clk); while (byte_stall);
    parse_byte(b, first);
    sent_count++;
    // typed rows yield exactly one record; it stands in for the predicted one
    if (typed) begin
      void'(due_records.pop_back());
      due_records.push_back(want);
    end
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (due_records.size() != 0);
  endtask

  task automatic send_packet();
    logic [7:0]  pkt[$];
    logic [7:0]  af[$];
    logic [7:0]  hb;
    logic [7:0]  fl;
    logic [7:0]  xf;
    int unsigned pick;
    int unsigned n;
    pick    = $urandom_range(0, 99);
    gaps_on = !calm && ($urandom_range(0, 3) != 0);
    if (pick >= 88) begin
      // stray bytes
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end else begin
      pkt = {SYNC_CODE, 8'($urandom), 8'($urandom)};
      hb  = 8'($urandom);
      if ($urandom_range(0, 3) != 0) hb[5] = 1'b1;
      pkt.push_back(hb);
      if (hb[5]) begin
        af = {};
        if ($urandom_range(0, 9) != 0) begin
          fl = 8'($urandom);
          af.push_back(fl);
          if (fl[4]) repeat (6) af.push_back(8'($urandom));
          if (fl[3]) repeat (6) af.push_back(8'($urandom));
          if (fl[2]) af.push_back(8'($urandom));
          if (fl[1]) begin
            n = $urandom_range(0, 6);
            af.push_back(8'(n));
            repeat (n) af.push_back(8'($urandom));
          end
          if (fl[0]) begin
            xf = 8'($urandom);
            af.push_back(8'($urandom));  // extension length, never checked
            af.push_back(xf);
            if (xf[7]) repeat (2) af.push_back(8'($urandom));
            if (xf[6]) repeat (3) af.push_back(8'($urandom));
            if (xf[5]) repeat (5) af.push_back(8'($urandom));
          end
          repeat ($urandom_range(0, 3)) af.push_back(8'hFF);
        end
        pkt.push_back(8'(af.size()));
        foreach (af[i]) pkt.push_back(af[i]);
      end
      if ($urandom_range(0, 19) == 0) n = PACKET_BYTES - pkt.size();
      else n = $urandom_range(0, 6);
      repeat (n) pkt.push_back(8'($urandom));
      if (pick >= 75) begin
        if ($urandom_range(0, 1) == 1) begin
          // cut short; the next packet start closes it off
          n = $urandom_range(1, pkt.size() - 1);
          while (pkt.size() > n) void'(pkt.pop_back());
        end else begin
          pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
        end
      end
      // after a whole packet, sometimes rely on the position wrapping
      foreach (pkt[i])
        send_byte(pkt[i], (i == 0) && (at_byte != 0 || $urandom_range(0, 1) == 1));
    end
  endtask

  // record side back-pressure, in bursts, with quiet stretches
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  bit          stall_on    = 1'b1;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 97 == 0) stall_on <= ($urandom_range(0, 2) != 0);
    if (rst || calm) begin
      rec_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      rec_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      rec_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_rec_t want;
    if (!rst && rec_valid && !rec_stall) begin
      if (due_records.size() == 0) begin
        $error("record with nothing expected, kind %0d", rec_data.record_kind);
        errors++;
      end else begin
        want = due_records.pop_front();
        check_field("record_kind", 33'(want.record_kind), 33'(rec_data.record_kind));
        check_field("packet_id", 33'(want.packet_id), 33'(rec_data.packet_id));
        check_field("error_flag", 33'(want.error_flag), 33'(rec_data.error_flag));
        check_field("unit_start", 33'(want.unit_start), 33'(rec_data.unit_start));
        check_field("priority_flag", 33'(want.priority_flag), 33'(rec_data.priority_flag));
        check_field("scrambling", 33'(want.scrambling), 33'(rec_data.scrambling));
        check_field("field_control", 33'(want.field_control), 33'(rec_data.field_control));
        check_field("continuity", 33'(want.continuity), 33'(rec_data.continuity));
        check_field("value_main", want.value_main, rec_data.value_main);
        check_field("value_aux", 33'(want.value_aux), 33'(rec_data.value_aux));
        check_field("status", 33'(want.status), 33'(rec_data.status));
        check_field("last_of_packet", 33'(want.last_of_packet), 33'(rec_data.last_of_packet));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ts_packet_header_parser_tb NOT OK");
    $finish;
  end

  initial begin
    // bad sync straight out of reset
    add_row(8'h00, 1'b1, 1'b1, closing_rec(KIND_HEADER, 2'd0, ST_BAD_SYNC));
    // every header bit set but the adaptation flag, payload only
    add_row(SYNC_CODE, 1'b1);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hDF, 1'b0);
    // adaptation length one past its limit
    add_row(SYNC_CODE, 1'b1);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h20, 1'b0);
    add_row(8'd184, 1'b0, 1'b1, closing_rec(KIND_PAYLOAD, 2'd2, ST_TRUNC));
    // top PID, private data longer than the adaptation field left
    add_row(SYNC_CODE, 1'b1);
    add_row(8'h1F, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h30, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h05, 1'b0);
    // largest legal adaptation length, then a new packet starts early
    add_row(SYNC_CODE, 1'b1);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h30, 1'b0);
    add_row(8'd183, 1'b0);
    add_row(SYNC_CODE, 1'b1);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    // cut inside the header by a packet with a bad sync
    add_row(8'h00, 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_byte(script[i].b, script[i].first, script[i].typed, script[i].want);
    wait_drained();

    while (sent_count < ITEMS) begin
      if (sent_count >= CALM_AFTER) calm = 1'b1;
      send_packet();
      if (!calm && $urandom_range(0, 29) == 0) wait_drained();
    end

    byte_valid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("ts_packet_header_parser_tb OK");
    else $display("ts_packet_header_parser_tb NOT OK");
    $finish;
  end

endmodule
